// ===== design/generation_handle_table_assert.svh =====
// ---------------------------------------------------------------------------
// Handle table assertion macros
// Shared assertion forms for the handle table; clocked on clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef GENERATION_HANDLE_TABLE_ASSERT_SVH
`define GENERATION_HANDLE_TABLE_ASSERT_SVH

// Flag a condition that must never hold outside reset.
`define GHT_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("handle table check failed");

// Flag a consequence that must hold in the cycle after its cause, reset included.
`define GHT_ASSERT_NEXT(name, cause, effect) \
  name: assert property (@(posedge clk) (cause) |=> (effect)) \
    else $error("handle table check failed");

`endif

// ===== design/ght_pkg.sv =====
// ---------------------------------------------------------------------------
// Handle table package
// Sizes, command and status codes, and the records shared by the modules.
// ---------------------------------------------------------------------------
package ght_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_BITS      = 6;
  localparam int GEN_BITS      = 26;
  localparam int REF_BITS      = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = 1;

  typedef logic [IDX_BITS-1:0] idx_t;

  localparam logic [IDX_BITS:0]   TABLE_END = (IDX_BITS+1)'(TABLE_ENTRIES);
  localparam idx_t                LAST_IDX  = IDX_BITS'(TABLE_ENTRIES - 1);
  localparam logic [REF_BITS-1:0] REF_SAT   = 16'hFFFE;

  localparam logic [3:0] CMD_ASSIGN   = 4'd0;
  localparam logic [3:0] CMD_TAKEOUT  = 4'd1;
  localparam logic [3:0] CMD_PUTBACK  = 4'd2;
  localparam logic [3:0] CMD_RELEASE  = 4'd3;
  localparam logic [3:0] CMD_GETMASK  = 4'd4;
  localparam logic [3:0] CMD_SETMASK  = 4'd5;
  localparam logic [3:0] CMD_SETOWNER = 4'd6;
  localparam logic [3:0] CMD_NEXT     = 4'd7;
  localparam logic [3:0] CMD_RELALL   = 4'd8;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_TYPE   = 3'd2;
  localparam logic [2:0] ST_NULL   = 3'd3;
  localparam logic [2:0] ST_CLOSED = 3'd4;
  localparam logic [2:0] ST_MODE   = 3'd5;
  localparam logic [2:0] ST_DENIED = 3'd6;

  typedef enum logic [3:0] {
    OP_IMM, OP_ASSIGN, OP_TAKE, OP_PUT, OP_RELEASE, OP_GETMASK,
    OP_SETMASK, OP_SETOWNER, OP_NEXT, OP_RELALL
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [2:0]          imm_status;
    idx_t                idx;
    logic [GEN_BITS-1:0] gen;
    logic [31:0]         obj;
    logic [3:0]          otype;
    logic [1:0]          mode;
    logic [31:0]         mask;
    logic [15:0]         owner;
    logic                take;
  } item_t;

  typedef struct packed {
    logic [31:0]         obj;
    logic [3:0]          otype;
    logic [15:0]         owner;
    logic [1:0]          mode;
    logic [31:0]         mask;
    logic [GEN_BITS-1:0] gen;
    logic [REF_BITS-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [31:0] object_out;
    logic [31:0] mask_out;
    logic        freed;
    logic        last;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// ===== design/ght_if.sv =====
// ---------------------------------------------------------------------------
// Handle table channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ght_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [31:0] handle;
  logic [31:0] object_ref;
  logic [3:0]  object_type;
  logic [1:0]  proc_mode;
  logic [31:0] access_mask;
  logic [15:0] owner_thread;
  logic        take_ref;

  modport source (output valid, cmd, handle, object_ref, object_type, proc_mode,
                  access_mask, owner_thread, take_ref, input ready);
  modport sink (input valid, cmd, handle, object_ref, object_type, proc_mode,
                access_mask, owner_thread, take_ref, output ready);
endinterface

interface ght_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] handle_out;
  logic [31:0] object_out;
  logic [31:0] mask_out;
  logic        freed;
  logic        last;

  modport source (output valid, status, handle_out, object_out, mask_out, freed, last,
                  input ready);
  modport sink (input valid, status, handle_out, object_out, mask_out, freed, last,
                output ready);
endinterface

// ===== design/ght_front.sv =====
// ---------------------------------------------------------------------------
// Handle table front end
// Accepts request words and classifies them for the back end.
// ---------------------------------------------------------------------------
module ght_front (
  ght_req_if.sink       req,
  input  logic          q_full,
  output logic          q_push,
  output ght_pkg::item_t q_item
);
  import ght_pkg::*;

  idx_t idx;
  logic out_range;

  assign idx       = req.handle[IDX_BITS-1:0];
  assign out_range = {1'b0, idx} >= TABLE_END;
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  always_comb begin
    q_item            = '0;
    q_item.idx        = idx;
    q_item.gen        = req.handle[31:IDX_BITS];
    q_item.obj        = req.object_ref;
    q_item.otype      = req.object_type;
    q_item.mode       = req.proc_mode;
    q_item.mask       = req.access_mask;
    q_item.owner      = req.owner_thread;
    q_item.take       = req.take_ref;
    q_item.op         = OP_IMM;
    q_item.imm_status = ST_OK;
    case (req.cmd)
      CMD_ASSIGN: begin
        if (req.object_type == 4'd0 || req.object_ref == 32'd0) begin
          q_item.imm_status = ST_TYPE;
        end else begin
          q_item.op = OP_ASSIGN;
        end
      end
      CMD_TAKEOUT, CMD_PUTBACK, CMD_RELEASE, CMD_GETMASK, CMD_SETMASK,
      CMD_SETOWNER: begin
        // null and out-of-range indexes never need the table
        if (idx == '0) begin
          q_item.imm_status = ST_NULL;
        end else if (out_range) begin
          q_item.imm_status = ST_CLOSED;
        end else begin
          case (req.cmd)
            CMD_TAKEOUT:  q_item.op = OP_TAKE;
            CMD_PUTBACK:  q_item.op = OP_PUT;
            CMD_RELEASE:  q_item.op = OP_RELEASE;
            CMD_GETMASK:  q_item.op = OP_GETMASK;
            CMD_SETMASK:  q_item.op = OP_SETMASK;
            default:      q_item.op = OP_SETOWNER;
          endcase
        end
      end
      CMD_NEXT:   q_item.op = OP_NEXT;
      CMD_RELALL: q_item.op = OP_RELALL;
      default:    q_item.op = OP_IMM;
    endcase
  end

endmodule

// ===== design/ght_queue.sv =====
// ---------------------------------------------------------------------------
// Handle table command queue
// Short FIFO of classified commands between front and back end.
// ---------------------------------------------------------------------------
module ght_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ght_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output ght_pkg::item_t pop_item,
  output logic           empty
);
  import ght_pkg::*;

  item_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full     = count == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_BITS+1)'(push && !full) - (QPTR_BITS+1)'(pop && !empty);
    end
  end

endmodule

// ===== design/ght_back.sv =====
// ---------------------------------------------------------------------------
// Handle table back end
// Runs commands against the entry memory and free list, drives responses.
// ---------------------------------------------------------------------------
module ght_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ght_pkg::item_t     q_item,
  output logic               q_pop,
  output ght_pkg::back_stat_t stat,
  ght_rsp_if.source          rsp
);
  import ght_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_EV} state_t;

  entry_t entry_mem [TABLE_ENTRIES];
  idx_t   next_mem  [TABLE_ENTRIES];

  state_t           state, state_next;
  idx_t             clr_idx, clr_next;
  idx_t             free_head, head_next;
  idx_t             free_tail, tail_next;
  logic [IDX_BITS:0] scan_idx, scan_next;
  item_t            cur, cur_next;
  logic             pend_valid, pend_v_next;
  logic [31:0]      pend_obj, pend_o_next;
  logic             out_valid;
  result_t          out_res;

  logic    rd_en;
  idx_t    rd_addr;
  entry_t  rdata;
  idx_t    rnext;
  logic    we;
  idx_t    waddr;
  entry_t  wdata;
  logic    nwe;
  idx_t    nwaddr;
  idx_t    nwdata;
  logic    emit;
  result_t res;
  logic    slot_free;
  logic    do_free;
  idx_t    act_idx;
  logic [2:0] lk;
  logic [2:0] st;
  entry_t  fe;

  assign slot_free  = !out_valid || rsp.ready;
  assign act_idx    = (state == S_EXEC) ? cur.idx : scan_idx[IDX_BITS-1:0];
  assign stat.clearing = state == S_CLEAR;
  assign stat.busy     = state != S_IDLE;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_res.status;
  assign rsp.handle_out = out_res.handle_out;
  assign rsp.object_out = out_res.object_out;
  assign rsp.mask_out   = out_res.mask_out;
  assign rsp.freed      = out_res.freed;
  assign rsp.last       = out_res.last;

  // entry check shared by the lookup commands
  always_comb begin
    lk = ST_OK;
    if (cur.gen != rdata.gen || rdata.obj == 32'd0 || !rdata.refs[0]) begin
      lk = ST_CLOSED;
    end else if (rdata.mode < cur.mode) begin
      lk = ST_MODE;
    end
  end

  always_comb begin
    fe       = rdata;
    fe.obj   = '0;
    fe.owner = '0;
    fe.mode  = '0;
    fe.refs  = '0;
    fe.gen   = rdata.gen + 1'b1;
  end

  always_comb begin
    state_next  = state;
    clr_next    = clr_idx;
    head_next   = free_head;
    tail_next   = free_tail;
    scan_next   = scan_idx;
    cur_next    = cur;
    pend_v_next = pend_valid;
    pend_o_next = pend_obj;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    waddr       = act_idx;
    wdata       = rdata;
    nwe         = 1'b0;
    nwaddr      = '0;
    nwdata      = '0;
    emit        = 1'b0;
    do_free     = 1'b0;
    st          = ST_OK;
    res         = '0;
    res.last    = 1'b1;

    case (state)
      S_CLEAR: begin
        we     = 1'b1;
        waddr  = clr_idx;
        wdata  = '0;
        nwe    = 1'b1;
        nwaddr = clr_idx;
        nwdata = (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr_idx + 1'b1;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_next = q_item;
          rd_en    = 1'b1;
          rd_addr  = (q_item.op == OP_ASSIGN) ? free_head : q_item.idx;
          if (q_item.op == OP_NEXT || q_item.op == OP_RELALL) begin
            scan_next   = (q_item.op == OP_NEXT) ? {1'b0, q_item.idx} + 1'b1
                                                 : (IDX_BITS+1)'(1);
            pend_v_next = 1'b0;
            state_next  = S_SCAN_RD;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (cur.op)
            OP_IMM: st = cur.imm_status;
            OP_ASSIGN: begin
              if (free_head == '0) begin
                st = ST_FULL;
              end else begin
                we          = 1'b1;
                waddr       = free_head;
                wdata       = rdata;
                wdata.obj   = cur.obj;
                wdata.otype = cur.otype;
                wdata.owner = cur.owner;
                wdata.mode  = cur.mode;
                wdata.mask  = cur.mask;
                wdata.refs  = REF_BITS'(1);
                res.handle_out = {rdata.gen, free_head};
                // the tail entry is the last one on the list
                if (free_head == free_tail) begin
                  head_next = '0;
                  tail_next = '0;
                end else begin
                  head_next = rnext;
                end
              end
            end
            OP_TAKE: begin
              st = lk;
              if (st == ST_OK && cur.otype != 4'd0 && rdata.otype != cur.otype) begin
                st = ST_TYPE;
              end
              if (st == ST_OK && (cur.mask & ~rdata.mask) != 32'd0) begin
                st = ST_DENIED;
              end
              if (st == ST_OK) begin
                res.mask_out = rdata.mask;
                if (cur.take) begin
                  res.object_out = rdata.obj;
                  if (rdata.refs < REF_SAT) begin
                    we         = 1'b1;
                    wdata.refs = rdata.refs + REF_BITS'(2);
                  end
                end
              end
            end
            OP_PUT: begin
              if (rdata.refs < REF_BITS'(2)) begin
                st = ST_CLOSED;
              end else if (rdata.refs == REF_BITS'(2)) begin
                do_free        = 1'b1;
                res.object_out = rdata.obj;
                res.freed      = 1'b1;
              end else begin
                we         = 1'b1;
                wdata.refs = rdata.refs - REF_BITS'(2);
              end
            end
            OP_RELEASE: begin
              st = lk;
              if (st == ST_OK) begin
                if (rdata.refs == REF_BITS'(1)) begin
                  do_free        = 1'b1;
                  res.object_out = rdata.obj;
                  res.freed      = 1'b1;
                end else begin
                  we         = 1'b1;
                  wdata.refs = rdata.refs & REF_SAT;
                end
              end
            end
            OP_GETMASK: begin
              st = lk;
              if (st == ST_OK) begin
                res.mask_out = rdata.mask;
              end
            end
            OP_SETMASK: begin
              st = lk;
              if (st == ST_OK) begin
                we         = 1'b1;
                wdata.mask = cur.mask;
              end
            end
            OP_SETOWNER: begin
              st = lk;
              if (st == ST_OK) begin
                we          = 1'b1;
                wdata.owner = cur.owner;
              end
            end
            default: st = ST_OK;
          endcase
          res.status = st;
        end
      end

      S_SCAN_RD: begin
        if (scan_idx >= TABLE_END) begin
          if (slot_free) begin
            emit = 1'b1;
            if (cur.op == OP_RELALL && pend_valid) begin
              res.object_out = pend_obj;
              res.freed      = 1'b1;
            end
            pend_v_next = 1'b0;
            state_next  = S_IDLE;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = scan_idx[IDX_BITS-1:0];
          state_next = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        if (cur.op == OP_NEXT) begin
          if (rdata.obj != 32'd0 && rdata.mode >= cur.mode) begin
            if (slot_free) begin
              emit           = 1'b1;
              res.handle_out = {rdata.gen, scan_idx[IDX_BITS-1:0]};
              state_next     = S_IDLE;
            end
          end else begin
            scan_next  = scan_idx + 1'b1;
            state_next = S_SCAN_RD;
          end
        end else if (rdata.mode >= cur.mode && rdata.owner == cur.owner) begin
          if (rdata.refs == REF_BITS'(1)) begin
            // hold each freed word until the next one shows whether it is last
            if (!pend_valid || slot_free) begin
              if (pend_valid) begin
                emit           = 1'b1;
                res.object_out = pend_obj;
                res.freed      = 1'b1;
                res.last       = 1'b0;
              end
              pend_v_next = 1'b1;
              pend_o_next = rdata.obj;
              do_free     = 1'b1;
              scan_next   = scan_idx + 1'b1;
              state_next  = S_SCAN_RD;
            end
          end else begin
            we         = 1'b1;
            wdata.refs = rdata.refs & REF_SAT;
            scan_next  = scan_idx + 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          scan_next  = scan_idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // free the entry and append it to the tail of the free list
    if (do_free) begin
      we    = 1'b1;
      waddr = act_idx;
      wdata = fe;
      if (free_tail == '0) begin
        head_next = act_idx;
      end else begin
        nwe    = 1'b1;
        nwaddr = free_tail;
        nwdata = act_idx;
      end
      tail_next = act_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      next_mem[nwaddr] <= nwdata;
    end
    if (rd_en) begin
      rnext <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      free_head  <= idx_t'(1);
      free_tail  <= LAST_IDX;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_next;
      free_head  <= head_next;
      free_tail  <= tail_next;
      pend_valid <= pend_v_next;
      pend_obj   <= pend_o_next;
      scan_idx   <= scan_next;
      cur        <= cur_next;
      if (emit) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/generation_handle_table.sv =====
// ---------------------------------------------------------------------------
// Generation handle table
// Fixed-size table of generation-checked handles with a FIFO free list.
// ---------------------------------------------------------------------------
// The req channel carries one command word per handshake; the rsp channel
// returns result words, each marked last on the final word of its command.
// Every command gives one word, except release all, which gives one word per
// freed entry (or a single empty word when nothing is freed).
// After reset the entry memory is cleared one entry per cycle; commands are
// queued but not run meanwhile.
// A command that touches one entry runs in the back end as a memory read,
// then an update that waits while rsp still holds the previous word. Next
// and release all walk the table entry by entry, each entry a memory read
// and then an evaluation. The entry memory has a registered read.
// A two-word queue decouples the sides: when rsp stalls, the back end holds
// its next word and the front keeps taking commands until the queue fills.
// ---------------------------------------------------------------------------
module generation_handle_table (
  input logic clk,
  input logic rst,
  ght_req_if.sink   req,
  ght_rsp_if.source rsp
);
  import ght_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  item_t      push_item;
  item_t      pop_item;
  back_stat_t bk_stat;

  ght_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  ght_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  ght_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .stat    (bk_stat),
    .rsp     (rsp)
  );

`include "generation_handle_table_assert.svh"

  `GHT_ASSERT_NEVER(a_push_full, q_push && q_full)
  `GHT_ASSERT_NEVER(a_pop_empty, q_pop && q_empty)
  `GHT_ASSERT_NEVER(a_pop_clear, q_pop && bk_stat.clearing)
  `GHT_ASSERT_NEXT(a_reset_quiet, rst, !rsp.valid)

endmodule
